### hw/rtl/bb_pkg.sv
// ----------------------------------------------------------------------------
// bb_pkg: shared types and constants for the 3x3 box blur
// Register defaults, field widths, FSM states, the queue entry and the
// reciprocal table used by the rounding divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bb_pkg;

    localparam int MAX_WIDTH_DEF = 2048;
    localparam int HEIGHT_LIMIT  = 4096;

    localparam int FW_W   = 12;
    localparam int FH_W   = 13;
    localparam int ROW_W  = 13;
    localparam int PIX_W  = 24;
    localparam int CH_W   = 8;
    localparam int SUM_W  = 12;
    localparam int CNT_W  = 4;
    localparam int NUM_W  = 13;
    localparam int DEN_W  = 5;
    localparam int RCP_W  = 16;
    localparam int CFG_W  = 13;

    localparam logic [FW_W-1:0] FW_RESET = 12'd640;
    localparam logic [FH_W-1:0] FH_RESET = 13'd480;

    localparam logic CFG_FRAME_WIDTH  = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef enum logic [1:0] {
        F_IDLE,
        F_LOAD,
        F_SUM
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_MUL,
        B_FIX,
        B_OUT
    } back_state_t;

    // neighbourhood mask and end-of-frame mark for one item
    typedef struct packed {
        logic emit;
        logic row0;
        logic row2;
        logic col0;
        logic col2;
        logic done;
    } emit_t;

    // one pending result: channel sums (0 red, 1 green, 2 blue) and count
    typedef struct packed {
        logic [2:0][SUM_W-1:0] sum;
        logic [CNT_W-1:0]      count;
        logic                  done;
    } job_t;

    // floor(2^16 / (2*count)); underestimates the quotient by at most one
    function automatic logic [RCP_W-1:0] recip(input logic [CNT_W-1:0] count);
        logic [RCP_W-1:0] r;
        case (count)
            4'd1:    r = 16'd32768;
            4'd2:    r = 16'd16384;
            4'd3:    r = 16'd10922;
            4'd4:    r = 16'd8192;
            4'd5:    r = 16'd6553;
            4'd6:    r = 16'd5461;
            4'd7:    r = 16'd4681;
            4'd8:    r = 16'd4096;
            4'd9:    r = 16'd3640;
            default: r = 16'd0;
        endcase
        return r;
    endfunction

endpackage

### hw/rtl/bb_ram.sv
// ----------------------------------------------------------------------------
// bb_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hw/rtl/bb_queue.sv
// ----------------------------------------------------------------------------
// bb_queue: two-entry job queue
// Decouples the window front end from the divider back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bb_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  bb_pkg::job_t  push_job,
    output logic          full,
    input  logic          pop,
    output bb_pkg::job_t  pop_job,
    output logic          empty
);

    bb_pkg::job_t entry_reg [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   fill_reg;

    assign full    = (fill_reg == 2'd2);
    assign empty   = (fill_reg == 2'd0);
    assign pop_job = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + 2'd1;
            end else if (pop && !push) begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

### hw/rtl/bb_front.sv
// ----------------------------------------------------------------------------
// bb_front: pixel intake, line stores and window
// Classifies each transfer, keeps the raster positions, shifts the 3x3
// window and pushes masked neighbourhood sums into the job queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bb_front #(
    parameter int MAX_WIDTH = bb_pkg::MAX_WIDTH_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic                     cfg_index,
    input  logic [bb_pkg::CFG_W-1:0] cfg_wdata,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [bb_pkg::PIX_W-1:0] s_tdata,
    input  logic                     s_tuser,
    output logic                     push,
    output bb_pkg::job_t             push_job,
    input  logic                     q_full
);

    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int WCW = ($clog2(MAX_WIDTH + 1) > bb_pkg::FW_W) ?
                         $clog2(MAX_WIDTH + 1) : bb_pkg::FW_W;
    localparam int ROW_W = bb_pkg::ROW_W;
    localparam int PIX_W = bb_pkg::PIX_W;

    bb_pkg::front_state_t state_reg, state_next;
    logic [bb_pkg::FW_W-1:0] fw_reg, fw_next;
    logic [bb_pkg::FH_W-1:0] fh_reg, fh_next;
    logic [ROW_W-1:0] in_row_reg, in_row_next, out_row_reg, out_row_next;
    logic [WCW-1:0]   in_col_reg, in_col_next, out_col_reg, out_col_next;
    logic [PIX_W-1:0] win_reg [3][3];
    logic [PIX_W-1:0] win_next [3][3];
    logic [PIX_W-1:0] pix_reg, pix_next;
    logic [WCW-1:0]   ic_reg, ic_next;
    bb_pkg::emit_t    flags_reg, flags_next, flags_in;

    logic [WCW-1:0]   w_eff;
    logic [ROW_W-1:0] h_eff;
    logic             draining, skip, emit_a, emit_b;
    logic [WCW-1:0]   in_col_inc, out_col_inc;
    logic [ROW_W-1:0] out_row_inc;
    logic             ram_we, ram_re;
    logic [PIX_W-1:0] up_rd, mid_rd;

    // effective geometry: zero acts as one, oversize clamps
    always_comb begin
        if (fw_reg == '0) begin
            w_eff = WCW'(1);
        end else if (WCW'(fw_reg) > WCW'(MAX_WIDTH)) begin
            w_eff = WCW'(MAX_WIDTH);
        end else begin
            w_eff = WCW'(fw_reg);
        end
        if (fh_reg == '0) begin
            h_eff = ROW_W'(1);
        end else if (fh_reg > ROW_W'(bb_pkg::HEIGHT_LIMIT)) begin
            h_eff = ROW_W'(bb_pkg::HEIGHT_LIMIT);
        end else begin
            h_eff = fh_reg;
        end
    end

    assign draining    = (in_row_reg >= h_eff);
    assign skip        = !draining && (s_tuser == bb_pkg::OP_DRAIN);
    assign emit_a      = (in_col_reg == '0) && (in_row_reg >= ROW_W'(2));
    assign emit_b      = (in_col_reg != '0) && (in_row_reg >= ROW_W'(1));
    assign in_col_inc  = in_col_reg + 1'b1;
    assign out_col_inc = out_col_reg + 1'b1;
    assign out_row_inc = out_row_reg + 1'b1;

    always_comb begin
        flags_in.emit = emit_a || emit_b;
        flags_in.row0 = (out_row_reg != '0);
        flags_in.row2 = (out_row_inc < h_eff);
        flags_in.col0 = (out_col_reg != '0);
        flags_in.col2 = emit_b && (out_col_inc < w_eff);
        flags_in.done = (emit_a || emit_b) && (out_row_reg == h_eff - 1'b1)
                        && (out_col_reg == w_eff - 1'b1);
    end

    assign s_tready = (state_reg == bb_pkg::F_IDLE);
    assign ram_re   = s_tvalid && s_tready;
    assign ram_we   = (state_reg == bb_pkg::F_LOAD);

    // upper holds the row two above the input, middle the row one above
    bb_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper_line (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ic_reg[AW-1:0]),
        .wdata (mid_rd),
        .re    (ram_re),
        .raddr (in_col_reg[AW-1:0]),
        .rdata (up_rd)
    );

    bb_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle_line (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ic_reg[AW-1:0]),
        .wdata (pix_reg),
        .re    (ram_re),
        .raddr (in_col_reg[AW-1:0]),
        .rdata (mid_rd)
    );

    always_comb begin
        state_next   = state_reg;
        fw_next      = fw_reg;
        fh_next      = fh_reg;
        in_row_next  = in_row_reg;
        in_col_next  = in_col_reg;
        out_row_next = out_row_reg;
        out_col_next = out_col_reg;
        win_next     = win_reg;
        pix_next     = pix_reg;
        ic_next      = ic_reg;
        flags_next   = flags_reg;
        push         = 1'b0;

        unique case (state_reg)
            bb_pkg::F_IDLE: begin
                if (s_tvalid && !skip) begin
                    pix_next   = draining ? '0 : s_tdata;
                    ic_next    = in_col_reg;
                    flags_next = flags_in;
                    if (flags_in.emit) begin
                        if (out_col_inc >= w_eff) begin
                            out_col_next = '0;
                            out_row_next = out_row_inc;
                        end else begin
                            out_col_next = out_col_inc;
                        end
                    end
                    if (in_col_inc >= w_eff) begin
                        in_col_next = '0;
                        in_row_next = in_row_reg + 1'b1;
                    end else begin
                        in_col_next = in_col_inc;
                    end
                    if (flags_in.done) begin
                        in_row_next  = '0;
                        in_col_next  = '0;
                        out_row_next = '0;
                        out_col_next = '0;
                    end
                    state_next = bb_pkg::F_LOAD;
                end
            end
            bb_pkg::F_LOAD: begin
                for (int r = 0; r < 3; r++) begin
                    win_next[r][0] = win_reg[r][1];
                    win_next[r][1] = win_reg[r][2];
                end
                win_next[0][2] = up_rd;
                win_next[1][2] = mid_rd;
                win_next[2][2] = pix_reg;
                state_next     = bb_pkg::F_SUM;
            end
            bb_pkg::F_SUM: begin
                if (!flags_reg.emit) begin
                    state_next = bb_pkg::F_IDLE;
                end else if (!q_full) begin
                    push = 1'b1;
                    if (flags_reg.done) begin
                        for (int r = 0; r < 3; r++) begin
                            for (int c = 0; c < 3; c++) begin
                                win_next[r][c] = '0;
                            end
                        end
                    end
                    state_next = bb_pkg::F_IDLE;
                end
            end
            default: begin
                state_next = bb_pkg::F_IDLE;
            end
        endcase

        // register write restarts the frame
        if (cfg_wr_en) begin
            if (cfg_index == bb_pkg::CFG_FRAME_WIDTH) begin
                fw_next = cfg_wdata[bb_pkg::FW_W-1:0];
            end else begin
                fh_next = cfg_wdata[bb_pkg::FH_W-1:0];
            end
            in_row_next  = '0;
            in_col_next  = '0;
            out_row_next = '0;
            out_col_next = '0;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    win_next[r][c] = '0;
                end
            end
        end
    end

    // masked sums over the window; the centre column is always in
    always_comb begin
        logic [2:0] rmask;
        logic [2:0] cmask;
        rmask = {flags_reg.row2, 1'b1, flags_reg.row0};
        cmask = {flags_reg.col2, 1'b1, flags_reg.col0};
        push_job.sum   = '0;
        push_job.count = '0;
        push_job.done  = flags_reg.done;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                if (rmask[r] && cmask[c]) begin
                    push_job.count = push_job.count + 1'b1;
                    for (int ch = 0; ch < 3; ch++) begin
                        push_job.sum[ch] = push_job.sum[ch]
                            + bb_pkg::SUM_W'(win_reg[r][c][8*ch +: 8]);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bb_pkg::F_IDLE;
            fw_reg      <= bb_pkg::FW_RESET;
            fh_reg      <= bb_pkg::FH_RESET;
            in_row_reg  <= '0;
            in_col_reg  <= '0;
            out_row_reg <= '0;
            out_col_reg <= '0;
            flags_reg   <= '0;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    win_reg[r][c] <= '0;
                end
            end
        end else begin
            state_reg   <= state_next;
            fw_reg      <= fw_next;
            fh_reg      <= fh_next;
            in_row_reg  <= in_row_next;
            in_col_reg  <= in_col_next;
            out_row_reg <= out_row_next;
            out_col_reg <= out_col_next;
            flags_reg   <= flags_next;
            win_reg     <= win_next;
        end
    end

    always_ff @(posedge aclk) begin
        pix_reg <= pix_next;
        ic_reg  <= ic_next;
    end

endmodule

### hw/rtl/bb_back.sv
// ----------------------------------------------------------------------------
// bb_back: rounding divider and output register
// Pops a job, forms (2*sum+count)/(2*count) by reciprocal multiply and a
// one-step correction, then holds the result until the sink takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bb_back (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  bb_pkg::job_t            pop_job,
    input  logic                    q_empty,
    output logic                    pop,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [bb_pkg::PIX_W-1:0] m_tdata,
    output logic                    m_tlast
);

    localparam int NUM_W = bb_pkg::NUM_W;
    localparam int DEN_W = bb_pkg::DEN_W;
    localparam int PRD_W = bb_pkg::NUM_W + bb_pkg::RCP_W;
    localparam int CH_W  = bb_pkg::CH_W;

    bb_pkg::back_state_t state_reg, state_next;
    bb_pkg::job_t        job_reg;
    logic [2:0][NUM_W-1:0] num_reg;
    logic [2:0][CH_W-1:0]  q0_reg;
    logic [2:0][CH_W-1:0]  res_reg;
    logic                  last_reg;

    logic [DEN_W-1:0]      den;
    logic [2:0][NUM_W-1:0] num_c;
    logic [2:0][CH_W-1:0]  q0_c;
    logic [2:0][CH_W-1:0]  q_c;

    assign den = {job_reg.count, 1'b0};

    always_comb begin
        logic [PRD_W-1:0] prod;
        logic [NUM_W-1:0] qd;
        logic [NUM_W-1:0] rem;
        for (int ch = 0; ch < 3; ch++) begin
            num_c[ch] = {job_reg.sum[ch], 1'b0} + NUM_W'(job_reg.count);
            prod      = PRD_W'(num_c[ch]) * PRD_W'(bb_pkg::recip(job_reg.count));
            q0_c[ch]  = prod[bb_pkg::RCP_W +: CH_W];
            qd        = NUM_W'(q0_reg[ch]) * NUM_W'(den);
            rem       = num_reg[ch] - qd;
            q_c[ch]   = (rem >= NUM_W'(den)) ? q0_reg[ch] + 1'b1 : q0_reg[ch];
        end
    end

    always_comb begin
        state_next = state_reg;
        pop        = 1'b0;
        unique case (state_reg)
            bb_pkg::B_IDLE: begin
                if (!q_empty) begin
                    pop        = 1'b1;
                    state_next = bb_pkg::B_MUL;
                end
            end
            bb_pkg::B_MUL: state_next = bb_pkg::B_FIX;
            bb_pkg::B_FIX: state_next = bb_pkg::B_OUT;
            bb_pkg::B_OUT: begin
                if (m_tready) begin
                    state_next = bb_pkg::B_IDLE;
                end
            end
            default: state_next = bb_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bb_pkg::B_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            job_reg <= pop_job;
        end
        if (state_reg == bb_pkg::B_MUL) begin
            num_reg <= num_c;
            q0_reg  <= q0_c;
        end
        if (state_reg == bb_pkg::B_FIX) begin
            res_reg  <= q_c;
            last_reg <= job_reg.done;
        end
    end

    assign m_tvalid = (state_reg == bb_pkg::B_OUT);
    assign m_tdata  = {res_reg[2], res_reg[1], res_reg[0]};
    assign m_tlast  = last_reg;

endmodule

### hw/rtl/box_blur_3x3.sv
// ----------------------------------------------------------------------------
// box_blur_3x3: streaming 3x3 box blur over an RGB raster
// Rounded mean of each pixel's in-frame neighbourhood, one result per pixel.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on the s_ channel in raster order, s_tuser = 0. After the
//   last pixel of a frame send frame_width+1 transfers with s_tuser = 1 to
//   flush; a drain transfer inside the frame is swallowed. Results leave on
//   the m_ channel in raster order, m_tlast marking the frame's last pixel,
//   after which the next input starts a new frame.
//   Frame size is written through cfg_wr_en/cfg_index/cfg_wdata while the
//   block is idle; a write restarts the frame.
// Timing:
//   Per pixel the front end steps through intake, line store read and
//   window sum, taking no new transfer before it is back at intake, and
//   waits in the sum step while the queue is full; a swallowed drain is
//   taken at intake alone. Per result the back end steps through pop,
//   reciprocal multiply, correction and output, and pops no new job until
//   the sink takes it. A result needs input one row plus one pixel past it.
// Reset and stall:
//   Reset sets 640x480 and clears positions and window; line stores are
//   left as they are. When the sink stalls, the result holds on m_tdata,
//   the two-entry queue fills and then s_tready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module box_blur_3x3 #(
    parameter int MAX_WIDTH = bb_pkg::MAX_WIDTH_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic                      cfg_index,
    input  logic [bb_pkg::CFG_W-1:0]  cfg_wdata,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // in_red [7:0], in_green [15:8], in_blue [23:16]
    input  logic [bb_pkg::PIX_W-1:0]  s_tdata,
    // op [0]: 0 pixel, 1 drain
    input  logic                      s_tuser,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // out_red [7:0], out_green [15:8], out_blue [23:16]
    output logic [bb_pkg::PIX_W-1:0]  m_tdata,
    // frame_done
    output logic                      m_tlast
);

    logic         push;
    logic         pop;
    logic         q_full;
    logic         q_empty;
    bb_pkg::job_t push_job;
    bb_pkg::job_t pop_job;

    // window, counters and line stores
    bb_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .push      (push),
        .push_job  (push_job),
        .q_full    (q_full)
    );

    // sums waiting for the divider
    bb_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .pop_job  (pop_job),
        .empty    (q_empty)
    );

    // rounding divide and output register
    bb_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .pop_job  (pop_job),
        .q_empty  (q_empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

### sim/tb_box_blur_3x3.sv
// ----------------------------------------------------------------------------
// tb_box_blur_3x3: self-checking testbench for the streaming 3x3 box blur
// Frames of random and extreme pixels go in on the s_ stream. A predictor
// keeps its own line stores, window and positions and works out each
// blurred pixel. Every m_ transfer is checked field by field against it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_box_blur_3x3;
    import bb_pkg::*;

    localparam int STALL_LIMIT = 5000;  // cycles with no transfer on either side
    localparam int SETTLE      = 16;    // cycles allowed after the last result
    localparam int RANDOM_ITEMS = 1400;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       done;
    } blur_px_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic                 cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [PIX_W-1:0]     s_tdata;   // in_red [7:0], in_green [15:8], in_blue [23:16]
    logic                 s_tuser;   // op
    logic                 m_tvalid;
    logic                 m_tready;
    logic [PIX_W-1:0]     m_tdata;   // out_red [7:0], out_green [15:8], out_blue [23:16]
    logic                 m_tlast;   // frame_done

    box_blur_3x3 dut (.*);

    // predictor state, pixels packed {red, green, blue}
    logic [FW_W-1:0]  pred_width;
    logic [FH_W-1:0]  pred_height;
    logic [23:0]      upper_store  [MAX_WIDTH_DEF];
    logic [23:0]      middle_store [MAX_WIDTH_DEF];
    logic [23:0]      win [3][3];
    int               in_row, in_col, out_row, out_col;

    blur_px_t         pending_px[$];
    int               mismatches;
    int               items_sent;
    int               quiet_cycles;
    int               hold_off;      // long sink hold-off, counted down by the sink
    bit               no_idle;       // stretch with no gaps on either side

    // ------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic int used_width();
        if (pred_width == 0) return 1;
        if (pred_width > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
        return pred_width;
    endfunction

    function automatic int used_height();
        if (pred_height == 0) return 1;
        if (pred_height > HEIGHT_LIMIT) return HEIGHT_LIMIT;
        return pred_height;
    endfunction

    function automatic void restart_frame();
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                win[r][c] = '0;
        in_row = 0;
        in_col = 0;
        out_row = 0;
        out_col = 0;
    endfunction

    // rounded mean of the in-frame neighbours around window column centre
    function automatic blur_px_t neighbourhood_mean(int centre, int w, int h);
        blur_px_t px;
        int sum [3];
        int cnt;
        bit rok [3];
        bit cok [3];
        int q [3];
        sum = '{0, 0, 0};
        cnt = 0;
        rok = '{out_row >= 1, 1'b1, out_row + 1 < h};
        cok = '{0, 0, 0};
        cok[centre] = 1'b1;
        if (out_col >= 1) cok[centre-1] = 1'b1;
        if (out_col + 1 < w && centre < 2) cok[centre+1] = 1'b1;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                if (rok[r] && cok[c]) begin
                    for (int ch = 0; ch < 3; ch++)
                        sum[ch] += (win[r][c] >> (16 - 8 * ch)) & 8'hFF;
                    cnt++;
                end
        for (int ch = 0; ch < 3; ch++)
            q[ch] = (2 * sum[ch] + cnt) / (2 * cnt);
        px.red   = q[0][7:0];
        px.green = q[1][7:0];
        px.blue  = q[2][7:0];
        px.done  = (out_row == h - 1) && (out_col == w - 1);
        return px;
    endfunction

    function automatic void predict_blur(logic op, logic [23:0] rgb);
        int w, h;
        bit got;
        blur_px_t px;
        logic [23:0] p, up, mid;
        w = used_width();
        h = used_height();
        got = 1'b0;
        // a drain inside the frame is swallowed
        if (in_row < h && op == OP_DRAIN) return;
        // past the frame's last pixel every item enters black
        p = (in_row >= h) ? 24'd0 : rgb;
        // last pixel of an output row is already in the window
        if (in_col == 0 && in_row >= 2) begin
            px = neighbourhood_mean(2, w, h);
            got = 1'b1;
        end
        up  = upper_store[in_col];
        mid = middle_store[in_col];
        upper_store[in_col]  = mid;
        middle_store[in_col] = p;
        for (int r = 0; r < 3; r++) begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        win[0][2] = up;
        win[1][2] = mid;
        win[2][2] = p;
        if (in_col >= 1 && in_row >= 1) begin
            px = neighbourhood_mean(1, w, h);
            got = 1'b1;
        end
        if (got) begin
            pending_px.push_back(px);
            if (++out_col >= w) begin
                out_col = 0;
                out_row++;
            end
        end
        if (++in_col >= w) begin
            in_col = 0;
            in_row++;
        end
        if (got && px.done) restart_frame();
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, int got, int want);
        $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        blur_px_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_px.size() == 0) begin
                report_mismatch("unexpected result transfer", m_tdata, -1);
            end else begin
                want = pending_px.pop_front();
                if (m_tdata[7:0] !== want.red)
                    report_mismatch("out_red", m_tdata[7:0], want.red);
                if (m_tdata[15:8] !== want.green)
                    report_mismatch("out_green", m_tdata[15:8], want.green);
                if (m_tdata[23:16] !== want.blue)
                    report_mismatch("out_blue", m_tdata[23:16], want.blue);
                if (m_tlast !== want.done)
                    report_mismatch("frame_done", m_tlast, want.done);
            end
        end
    end

    // watchdog: ends the run when nothing moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // sink: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------
    function automatic int gap_len();
        int roll;
        if (no_idle) return 0;
        roll = $urandom_range(99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    initial begin
        int stall_left;
        stall_left = 0;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off > 0) begin
                m_tready <= 1'b0;
                hold_off--;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if (!no_idle && $urandom_range(7) == 0) begin
                stall_left = gap_len();
                m_tready <= (stall_left == 0);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // source side helpers
    // ------------------------------------------------------------------
    // one input transfer, preceded by a random gap
    task automatic send_item(logic op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {b, g, r};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_blur(op, {r, g, b});
        items_sent++;
    endtask

    task automatic send_random(logic op);
        send_item(op, 8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)));
    endtask

    // lets every expected result arrive, then the block settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_px.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [CFG_W-1:0] value);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_FRAME_WIDTH) pred_width = value[FW_W-1:0];
        else                        pred_height = value[FH_W-1:0];
        restart_frame();
    endtask

    task automatic set_frame(int w, int h);
        write_reg(CFG_FRAME_WIDTH, CFG_W'(w));
        write_reg(CFG_FRAME_HEIGHT, CFG_W'(h));
    endtask

    // a full frame of random pixels then its flush; noise is the chance in
    // percent of a stray drain inside the frame or a pixel op in the flush
    task automatic send_frame(int noise);
        int total;
        total = used_width() * used_height();
        for (int i = 0; i < total; i++) begin
            if ($urandom_range(99) < noise) send_random(OP_DRAIN);
            send_random(OP_PIXEL);
        end
        for (int i = 0; i <= used_width(); i++)
            send_random(($urandom_range(99) < noise) ? OP_PIXEL : OP_DRAIN);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_small_frames();
        // single pixel frame, full white then full black
        set_frame(1, 1);
        send_item(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF);
        send_item(OP_DRAIN, 8'h00, 8'h00, 8'h00);
        send_item(OP_DRAIN, 8'hFF, 8'h00, 8'hFF);
        send_item(OP_PIXEL, 8'h00, 8'h00, 8'h00);
        send_item(OP_PIXEL, 8'hA5, 8'h5A, 8'hFF);   // pixel after the frame acts as a drain
        send_item(OP_DRAIN, 8'h00, 8'h00, 8'h00);
        // 3x3 checkerboard, a stray drain in the middle of the frame
        set_frame(3, 3);
        for (int i = 0; i < 9; i++) begin
            if (i == 4) send_item(OP_DRAIN, 8'h12, 8'h34, 8'h56);
            if (i[0]) send_item(OP_PIXEL, 8'hFF, 8'h00, 8'hFF);
            else      send_item(OP_PIXEL, 8'h00, 8'hFF, 8'h00);
        end
        for (int i = 0; i < 4; i++) send_item(OP_DRAIN, 8'hFF, 8'hFF, 8'hFF);
    endtask

    task automatic test_register_clamping();
        // zero sizes act as one
        set_frame(0, 0);
        send_random(OP_PIXEL);
        send_random(OP_DRAIN);
        send_random(OP_PIXEL);
        // width above the limit clamps to the widest row; start of a row only
        set_frame(13'h1FFF, 2);
        repeat (40) send_random(OP_PIXEL);
        // height above the limit: a few rows, then restarted by a write
        set_frame(3, 13'h1FFF);
        repeat (30) send_random(OP_PIXEL);
        write_reg(CFG_FRAME_HEIGHT, CFG_W'(2));
        send_frame(0);
    endtask

    task automatic test_restart_mid_frame();
        set_frame(4, 3);
        for (int i = 0; i < 6; i++) send_random(OP_PIXEL);
        // the partly received frame is dropped by the write
        write_reg(CFG_FRAME_WIDTH, 5);
        send_frame(0);
    endtask

    task automatic test_backpressure();
        set_frame(6, 5);
        hold_off = 300;              // sink stalls while the source keeps offering
        send_frame(5);
        wait_idle();                 // source pauses until every result is in
        send_frame(5);
    endtask

    task automatic test_random_frames();
        int stop_at, w, h;
        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at) begin
            no_idle = ($urandom_range(4) == 0);
            if ($urandom_range(1)) begin
                w = ($urandom_range(9) == 0) ? $urandom_range(64, 13) : $urandom_range(10, 1);
                h = ($urandom_range(9) == 0) ? $urandom_range(16, 7) : $urandom_range(6, 1);
                set_frame(w, h);
            end
            if ($urandom_range(19) == 0) begin
                // broken frame: cut short and restarted by a register write
                repeat ($urandom_range(used_width() * used_height())) send_random(OP_PIXEL);
                write_reg(CFG_FRAME_HEIGHT, CFG_W'(used_height()));
            end else begin
                send_frame(4);
            end
        end
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_FRAME_WIDTH;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tuser = OP_PIXEL;
        s_tdata = '0;
        mismatches = 0;
        items_sent = 0;
        quiet_cycles = 0;
        hold_off = 0;
        no_idle = 1'b0;
        pred_width = FW_RESET;
        pred_height = FH_RESET;
        for (int i = 0; i < MAX_WIDTH_DEF; i++) begin
            upper_store[i] = '0;
            middle_store[i] = '0;
        end
        restart_frame();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        test_small_frames();
        test_register_clamping();
        test_restart_mid_frame();
        test_backpressure();
        test_random_frames();

        wait_idle();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### sim.f
hw/rtl/bb_pkg.sv
hw/rtl/bb_ram.sv
hw/rtl/bb_queue.sv
hw/rtl/bb_front.sv
hw/rtl/bb_back.sv
hw/rtl/box_blur_3x3.sv
sim/tb_box_blur_3x3.sv
